FILE: hdl/bpbl_pkg.sv
`default_nettype none
package bpbl_pkg;
   localparam int NODE_COUNT_DEF  = 1024;
   localparam int PLANE_COUNT_DEF = 1024;
   localparam int MAX_DEPTH_DEF   = 64;
   localparam int SLOT_W          = 10;
   localparam int CELL_W          = 15;
   localparam logic [1:0] CMD_LOAD_NODE  = 2'd0;
   localparam logic [1:0] CMD_LOAD_PLANE = 2'd1;
   localparam logic [1:0] CMD_QUERY      = 2'd2;
   localparam logic signed [31:0] LEAF_EMPTY = -32'sd1;
   localparam logic signed [31:0] LEAF_SOLID = -32'sd2;
   localparam int NODE_W   = 32 + 32 + 32 + CELL_W;
   localparam int NORM_W   = 54;
   localparam int ACC_W    = 64;
   // one product of the shared multiply-accumulate unit
   typedef struct packed {
      logic                     clr;
      logic                     en;
      logic signed [32:0]       a;
      logic signed [32:0]       b;
   } mac_ctl_type;
endpackage
`default_nettype wire

FILE: hdl/bsp_point_box_locate_unit.sv
// sequence: a load is written on acceptance; a query, per node visited, reads the node, checks
//   its plane index, reads the plane, runs seven products on the one shared multiplier, drains, decides
// flow: one item at a time, accepted again once its result is registered;
//   an untaken result holds the next
// reset: synchronous, clears the sequencer and output valid; tables undefined until written
`default_nettype none
module bsp_point_box_locate_unit import bpbl_pkg::*; #(
   parameter int NODE_COUNT  = NODE_COUNT_DEF,
   parameter int PLANE_COUNT = PLANE_COUNT_DEF,
   parameter int MAX_DEPTH   = MAX_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // slot, vec_x, vec_y, vec_z, word_a, word_b, word_c, word_d, zero fill
   input  wire logic [231:0] req_tdata,
   // cmd
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // cell_id, solid flag, fault
   output logic [23:0]       rsp_tdata
);
   localparam int NA = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int PA = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam logic [3:0] S_IDLE = 4'd0, S_NRD = 4'd1, S_NCHK = 4'd2,
      S_PRD = 4'd3, S_MUL = 4'd4, S_WAIT = 4'd5, S_DEC = 4'd6, S_OUT = 4'd7;

   logic [1:0]  cmd;
   logic [SLOT_W-1:0] slot;
   logic signed [31:0] vx, vy, vz, wa, wb, wc;
   logic [CELL_W-1:0] wd;
   assign slot = req_tdata[9:0];
   assign vx = req_tdata[41:10];
   assign vy = req_tdata[73:42];
   assign vz = req_tdata[105:74];
   assign wa = req_tdata[137:106];
   assign wb = req_tdata[169:138];
   assign wc = req_tdata[201:170];
   assign wd = req_tdata[216:202];
   assign cmd = req_tuser;

   logic [3:0] state_ff, state_in;
   logic signed [31:0] p_ff [3], p_in [3], e_ff [3], e_in [3];
   logic [NA-1:0] cur_ff, cur_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [2:0] step_ff, step_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic solid_ff, solid_in, fault_ff, fault_in, rv_ff, rv_in;
   logic [CELL_W+1:0] out_ff, out_in;

   wire accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   logic nwe, pwe;
   logic [NODE_W-1:0] nrd;
   logic [NORM_W+31:0] prd;
   logic [NA-1:0] nwa;
   logic [PA-1:0] pwa, pra;
   assign nwa = NA'(slot);
   assign pwa = PA'(slot);
   assign nwe = accept && cmd == CMD_LOAD_NODE && 32'(slot) < NODE_COUNT;
   assign pwe = accept && cmd == CMD_LOAD_PLANE && 32'(slot) < PLANE_COUNT;

   logic signed [31:0] n_pl, n_fr, n_bk;
   logic [CELL_W-1:0]  n_cell;
   assign {n_cell, n_bk, n_fr, n_pl} = nrd;
   assign pra = PA'(n_pl);

   bpbl_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_nodes (
      .clock, .wr_en(nwe), .wr_addr(nwa), .wr_data({wd, wc, wb, wa}),
      .rd_addr(cur_ff), .rd_data(nrd));
   bpbl_ram #(.WIDTH(NORM_W + 32), .DEPTH(PLANE_COUNT)) u_planes (
      .clock, .wr_en(pwe), .wr_addr(pwa),
      .wr_data({wa, vz[17:0], vy[17:0], vx[17:0]}),
      .rd_addr(pra), .rd_data(prd));

   logic signed [17:0] nrm [3];
   logic signed [31:0] offs;
   assign nrm[0] = prd[17:0];
   assign nrm[1] = prd[35:18];
   assign nrm[2] = prd[53:36];
   assign offs = prd[85:54];

   mac_ctl_type mc;
   logic signed [ACC_W-1:0] acc;
   bpbl_mac u_mac (.clock, .ctl(mc), .acc);

   logic signed [18:0] nabs;
   logic [1:0] k;
   logic signed [31:0] nxt;
   always_comb begin
      mc = '0;
      k = (step_ff >= 3'd3) ? 2'(step_ff - 3'd3) : step_ff[1:0];
      nabs = nrm[k][17] ? -19'(nrm[k]) : 19'(nrm[k]);
      if (state_ff == S_PRD) mc.clr = 1'b1;
      if (state_ff == S_MUL) begin
         mc.en = 1'b1;
         if (step_ff < 3'd3) begin
            mc.a = 33'(nrm[k]);
            mc.b = 33'(p_ff[k]);
         end else if (step_ff < 3'd6) begin
            mc.a = 33'(nabs);
            mc.b = -33'(e_ff[k]);
         end else begin
            mc.a = -33'(offs);
            mc.b = 33'sd65536;
         end
      end
   end

   assign nxt = acc[ACC_W-1] ? n_bk : n_fr;

   always_comb begin
      state_in = state_ff; p_in = p_ff; e_in = e_ff; cur_in = cur_ff;
      depth_in = depth_ff; step_in = step_ff; cell_in = cell_ff;
      solid_in = solid_ff; fault_in = fault_ff; rv_in = rv_ff; out_in = out_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: if (accept) begin
            cell_in = '0; solid_in = 1'b0; fault_in = 1'b0;
            p_in[0] = vx; p_in[1] = vy; p_in[2] = vz;
            e_in[0] = wa; e_in[1] = wb; e_in[2] = wc;
            cur_in = NA'(slot); depth_in = '0;
            if (cmd == CMD_QUERY) begin
               if (32'(slot) >= NODE_COUNT) begin
                  fault_in = 1'b1; state_in = S_OUT;
               end else state_in = S_NRD;
            end else state_in = S_OUT;
         end
         S_NRD: state_in = S_NCHK;
         S_NCHK: begin
            if (n_pl < 0 || n_pl >= PLANE_COUNT) begin
               fault_in = 1'b1; state_in = S_OUT;
            end else state_in = S_PRD;
         end
         S_PRD: begin step_in = '0; state_in = S_MUL; end
         S_MUL: begin
            if (step_ff == 3'd6) begin step_in = '0; state_in = S_WAIT; end
            else step_in = step_ff + 3'd1;
         end
         S_WAIT: begin
            // drain the product register into the accumulator
            if (step_ff == 3'd1) state_in = S_DEC;
            else step_in = step_ff + 3'd1;
         end
         S_DEC: begin
            state_in = S_OUT;
            if (nxt == LEAF_EMPTY) cell_in = n_cell;
            else if (nxt == LEAF_SOLID) solid_in = 1'b1;
            else if (nxt < 0 || nxt >= NODE_COUNT) fault_in = 1'b1;
            else if (32'(depth_ff) + 1 >= MAX_DEPTH) fault_in = 1'b1;
            else begin
               cur_in = NA'(nxt); depth_in = depth_ff + 1'b1; state_in = S_NRD;
            end
         end
         S_OUT: begin
            // wait here while the previous result is still held
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1; out_in = {fault_ff, solid_ff, cell_ff}; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; step_ff <= '0; depth_ff <= '0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; step_ff <= step_in;
         depth_ff <= depth_in;
      end
      p_ff <= p_in; e_ff <= e_in; cur_ff <= cur_in; cell_ff <= cell_in;
      solid_ff <= solid_in; fault_ff <= fault_in; out_ff <= out_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {7'd0, out_ff};

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while waiting");
   a_onehot_res: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones({out_ff[CELL_W+1], out_ff[CELL_W],
                                 out_ff[CELL_W-1:0] != '0}) <= 1)
      else $error("conflicting result flags");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      32'(depth_ff) < MAX_DEPTH) else $error("depth bound passed");
`endif
endmodule
`default_nettype wire

FILE: hdl/bpbl_ram.sv
`default_nettype none
module bpbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hdl/bpbl_mac.sv
`default_nettype none
module bpbl_mac import bpbl_pkg::*; (
   input  wire logic                    clock,
   input  wire mac_ctl_type             ctl,
   output logic signed [ACC_W-1:0]      acc
);
   logic signed [ACC_W-1:0] prod_ff, acc_ff, acc_in;
   logic                    en_ff, clr_ff;
   // product registered, then accumulated
   always_ff @(posedge clock) begin
      prod_ff <= ACC_W'(ctl.a * ctl.b);
      en_ff   <= ctl.en;
      clr_ff  <= ctl.clr;
      acc_ff  <= acc_in;
   end
   always_comb begin
      acc_in = acc_ff;
      if (clr_ff) acc_in = '0;
      else if (en_ff) acc_in = acc_ff + prod_ff;
   end
   assign acc = acc_ff;
endmodule
`default_nettype wire

FILE: bench/bsp_point_box_locate_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module bsp_point_box_locate_unit_test;
   import bpbl_pkg::*;

   localparam int NODES  = NODE_COUNT_DEF;
   localparam int PLANES = PLANE_COUNT_DEF;
   localparam int DEPTH  = MAX_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [1:0] CMD_NONE = 2'd3;

   typedef struct {
      logic [14:0] cell_num;
      logic        solid;
      logic        fault;
   } answer_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [231:0] req_tdata = '0;
   logic [1:0]   req_tuser = CMD_LOAD_NODE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;

   // slot, vec_x, vec_y, vec_z, word_a, word_b, word_c, word_d, zero fill
   // cell_id, solid flag, fault on the response side
   bsp_point_box_locate_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // private copy of the node and plane tables
   logic signed [31:0] node_plane [NODES];
   logic signed [31:0] node_front [NODES];
   logic signed [31:0] node_back  [NODES];
   logic [14:0]        node_cell  [NODES];
   bit                 node_written [NODES];
   logic signed [17:0] plane_norm [PLANES][3];
   logic signed [31:0] plane_off  [PLANES];
   bit                 plane_written [PLANES];

   answer_type pending_answers[$];
   int      mismatches = 0;
   int      cycles = 0;
   int      rsp_hold = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response stall pattern
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         rsp_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (reset)
         rsp_tready <= 1'b0;
      else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %h", rsp_tdata);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[14:0] !== want.cell_num || rsp_tdata[15] !== want.solid ||
                rsp_tdata[16] !== want.fault) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: cell %0d solid %b fault %b, got cell %0d solid %b fault %b",
                           want.cell_num, want.solid, want.fault,
                           rsp_tdata[14:0], rsp_tdata[15], rsp_tdata[16]);
            end
         end
      end
   end

   // walk the tree; returns 0 if the walk would touch an entry never loaded
   function automatic bit locate_point(input logic [9:0] start,
                                       input logic signed [31:0] px, py, pz,
                                       input logic signed [31:0] ex, ey, ez,
                                       output answer_type ans);
      int cur;
      int pi;
      longint side_dist, reach, n;
      logic signed [31:0] nxt;
      ans = '{0, 0, 0};
      cur = start;
      for (int lvl = 0; lvl < DEPTH; lvl++) begin
         if (!node_written[cur]) return 1'b0;
         pi = node_plane[cur];
         if (pi < 0 || pi >= PLANES) begin
            ans.fault = 1'b1;
            return 1'b1;
         end
         if (!plane_written[pi]) return 1'b0;
         n = plane_norm[pi][0];
         side_dist = n * longint'(px);
         reach = ((n < 0) ? -n : n) * longint'(ex);
         n = plane_norm[pi][1];
         side_dist += n * longint'(py);
         reach += ((n < 0) ? -n : n) * longint'(ey);
         n = plane_norm[pi][2];
         side_dist += n * longint'(pz);
         reach += ((n < 0) ? -n : n) * longint'(ez);
         side_dist = side_dist - longint'(plane_off[pi]) * 65536 - reach;
         nxt = (side_dist >= 0) ? node_front[cur] : node_back[cur];
         if (nxt == LEAF_EMPTY) begin
            ans.cell_num = node_cell[cur];
            return 1'b1;
         end
         if (nxt == LEAF_SOLID) begin
            ans.solid = 1'b1;
            return 1'b1;
         end
         if (nxt < 0 || nxt >= NODES) begin
            ans.fault = 1'b1;
            return 1'b1;
         end
         cur = nxt;
      end
      ans.fault = 1'b1;
      return 1'b1;
   endfunction

   // predict and update tables; 0 means the item must not be sent
   function automatic bit predict_answer(input logic [1:0] cmd, input logic [9:0] slot,
                                         input logic [31:0] x, y, z, a, b, c,
                                         input logic [14:0] d, output answer_type ans);
      ans = '{0, 0, 0};
      case (cmd)
         CMD_LOAD_NODE: begin
            node_plane[slot] = a;
            node_front[slot] = b;
            node_back[slot]  = c;
            node_cell[slot]  = d;
            node_written[slot] = 1'b1;
         end
         CMD_LOAD_PLANE: begin
            plane_norm[slot][0] = x[17:0];
            plane_norm[slot][1] = y[17:0];
            plane_norm[slot][2] = z[17:0];
            plane_off[slot] = a;
            plane_written[slot] = 1'b1;
         end
         CMD_QUERY: return locate_point(slot, x, y, z, a, b, c, ans);
         default: ;
      endcase
      return 1'b1;
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [9:0] slot,
                            input logic [31:0] x, y, z, a, b, c, input logic [14:0] d);
      int gap;
      answer_type ans;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {15'd0, d, c, b, a, z, y, x, slot};
      do @(posedge clock); while (!req_tready);
      void'(predict_answer(cmd, slot, x, y, z, a, b, c, d, ans));
      pending_answers.push_back(ans);
   endtask

   task automatic drain_answers;
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DEPTH * 10 + 10) @(posedge clock);
   endtask

   // a query is only sent when its whole walk reads loaded entries
   task automatic send_query(input logic [9:0] slot, input logic [31:0] x, y, z, a, b, c);
      answer_type ans;
      if (locate_point(slot, x, y, z, a, b, c, ans))
         send_item(CMD_QUERY, slot, x, y, z, a, b, c, 15'($urandom));
   endtask

   function automatic logic [31:0] pick_child();
      case ($urandom_range(0, 9))
         0, 1:    return LEAF_EMPTY;
         2, 3:    return LEAF_SOLID;
         4:       return ($urandom_range(0, 1)) ? 32'(-3 - $urandom_range(0, 9))
                                                : 32'(NODES + $urandom_range(0, 100));
         default: return $urandom_range(0, 31);
      endcase
   endfunction

   task automatic test_tree_basics;
      // planes: x = offset, y = 0, normal with garbage upper bits, extremes
      send_item(CMD_LOAD_PLANE, 0, 32'hFFFC_0000 | 32'h1_0000, 0, 0, 32'h0001_0000, 0, 0, 0);
      send_item(CMD_LOAD_PLANE, 1, 32'h0001_FFFF, 32'hABCE_0000, 32'h5556_0000,
                32'h7FFF_FFFF, 0, 0, 0);
      send_item(CMD_LOAD_PLANE, 2, 32'h8002_0000, 32'hFFFF_FFFF, 32'h1_0000,
                32'h8000_0000, 0, 0, 0);
      send_item(CMD_LOAD_PLANE, 1023, 32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0, 0);
      // node 0: split on x = 1, front to node 1, back empty
      send_item(CMD_LOAD_NODE, 0, 0, 0, 0, 0, 1, LEAF_EMPTY, 15'd7);
      send_item(CMD_LOAD_NODE, 1, 0, 0, 0, 1, LEAF_SOLID, LEAF_EMPTY, 15'h7FFF);
      send_item(CMD_LOAD_NODE, 1023, 32'hFFFF_FFFF, 0, 0, 1023, LEAF_EMPTY,
                LEAF_SOLID, 15'd1);
      send_item(CMD_NONE, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF);
      send_query(0, 32'h0000_0000, 0, 0, 0, 0, 0);
      send_query(0, 32'h0001_0000, 0, 0, 0, 0, 0);
      send_query(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
      send_query(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
      // box straddling the plane, then negative extents
      send_query(0, 32'h0002_0000, 0, 0, 32'h0002_0000, 32'h7FFF_FFFF, 0);
      send_query(0, 32'h0000_8000, 0, 0, 32'hFFFF_0000, 32'h8000_0000, 32'h8000_0000);
      send_query(1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_query(1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
   endtask

   task automatic test_faults;
      send_item(CMD_LOAD_NODE, 2, 0, 0, 0, 32'hFFFF_FFFB, LEAF_EMPTY, LEAF_EMPTY, 1);
      send_item(CMD_LOAD_NODE, 3, 0, 0, 0, 1024, LEAF_EMPTY, LEAF_EMPTY, 1);
      send_item(CMD_LOAD_NODE, 4, 0, 0, 0, 0, 32'hFFFF_FFFD, 1024, 1);
      send_item(CMD_LOAD_NODE, 5, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
      // self loop runs into the depth bound
      send_item(CMD_LOAD_NODE, 6, 0, 0, 0, 0, 6, 6, 1);
      send_query(2, 0, 0, 0, 0, 0, 0);
      send_query(3, 0, 0, 0, 0, 0, 0);
      send_query(4, 32'h0005_0000, 0, 0, 0, 0, 0);
      send_query(4, 0, 0, 0, 0, 0, 0);
      send_query(5, 32'h0005_0000, 0, 0, 0, 0, 0);
      send_query(5, 0, 0, 0, 0, 0, 0);
      send_query(6, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic test_random_walks;
      logic [31:0] px, py, pz, ex, ey, ez;
      // fill a small forest so that random walks stay on loaded entries
      for (int i = 0; i < 16; i++)
         send_item(CMD_LOAD_PLANE, 10'(i), $urandom, $urandom, $urandom,
                   $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 8))) <<< 16,
                   0, 0, 0);
      for (int i = 0; i < 32; i++)
         send_item(CMD_LOAD_NODE, 10'(i), 0, 0, 0, $urandom_range(0, 15),
                   pick_child(), pick_child(), 15'($urandom));
      for (int n = 0; n < 680; n++) begin
         case ($urandom_range(0, 19))
            0: send_item(CMD_LOAD_PLANE, 10'($urandom_range(0, 15)), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, 15'($urandom));
            1, 2: send_item(CMD_LOAD_NODE, 10'($urandom_range(0, 31)), $urandom, $urandom,
                            $urandom,
                            ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 15),
                            pick_child(), pick_child(), 15'($urandom));
            3: send_item(CMD_LOAD_NODE, 10'($urandom_range(32, 1023)), $urandom, $urandom,
                         $urandom, $urandom_range(0, 15), pick_child(), pick_child(),
                         15'($urandom));
            4: send_item(CMD_NONE, 10'($urandom), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, 15'($urandom));
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  px = $urandom; py = $urandom; pz = $urandom;
               end else begin
                  px = 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
                  py = $urandom_range(0, 1) ? $urandom : 0;
                  pz = 32'($signed($urandom_range(0, 2000000)) - 1000000);
               end
               if ($urandom_range(0, 2) == 0) begin
                  ex = 0; ey = 0; ez = 0;
               end else if ($urandom_range(0, 4) == 0) begin
                  ex = $urandom; ey = $urandom; ez = $urandom;
               end else begin
                  ex = $urandom_range(0, 1 << 18); ey = $urandom_range(0, 1 << 18);
                  ez = $urandom_range(0, 1 << 18);
               end
               send_query(10'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                         : $urandom_range(0, 31)),
                          px, py, pz, ex, ey, ez);
            end
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tree_basics();
      drain_answers();
      test_faults();
      drain_answers();
      test_random_walks();
      drain_answers();
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
hdl/bpbl_pkg.sv
hdl/bpbl_ram.sv
hdl/bpbl_mac.sv
hdl/bsp_point_box_locate_unit.sv
bench/bsp_point_box_locate_unit_test.sv
